// ----- rtl/kms_pkg.sv -----
// kms_pkg: shared types and constants for the keypad matrix scanner.
// No dependencies.
package kms_pkg;

  localparam int unsigned ROW_BITS = 3;
  localparam int unsigned COL_BITS = 3;
  localparam int unsigned COUNT_BITS = 4;
  localparam int unsigned LINE_BITS = 8;
  localparam int unsigned MS_BITS = 16;
  localparam int unsigned CODE_BITS = 8;

  localparam logic [1:0] REG_MIN_INTERVAL = 2'd0;
  localparam logic [1:0] REG_ROWS_IN_USE = 2'd1;
  localparam logic [1:0] REG_COLUMNS_IN_USE = 2'd2;

  localparam logic [MS_BITS-1:0] MIN_INTERVAL_RESET = 16'd20;
  localparam logic [MS_BITS-1:0] ELAPSED_MAX = 16'hFFFF;
  localparam logic [LINE_BITS-1:0] ROWS_IDLE = 8'hFF;

  localparam logic [CODE_BITS-1:0] CODE_RELEASED = 8'h00;
  localparam logic [1:0] CODE_SINGLE_TAG = 2'b01;
  localparam logic [CODE_BITS-1:0] CODE_SEVERAL = 8'h80;

  typedef enum logic [1:0] {
    EVENT_RELEASED = 2'd0,
    EVENT_SINGLE = 2'd1,
    EVENT_SEVERAL = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [MS_BITS-1:0] min_interval_ms;
    logic [COUNT_BITS-1:0] rows;
    logic [COUNT_BITS-1:0] columns;
  } cfg_t;

  typedef struct packed {
    logic [LINE_BITS-1:0] row_drive;
    logic event_valid;
    event_kind_t event_kind;
    logic [ROW_BITS-1:0] key_row;
    logic [COL_BITS-1:0] key_column;
  } result_t;

endpackage

// ----- rtl/kms_cfg.sv -----
// kms_cfg: configuration registers; row and column counts are clamped on write.
// Depends on kms_pkg.
module kms_cfg #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLUMNS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [1:0] wr_index,
  input  logic [kms_pkg::MS_BITS-1:0] wr_data,
  output kms_pkg::cfg_t cfg
);

  localparam logic [kms_pkg::COUNT_BITS-1:0] ROWS_MAX = kms_pkg::COUNT_BITS'(MAX_ROWS);
  localparam logic [kms_pkg::COUNT_BITS-1:0] COLS_MAX = kms_pkg::COUNT_BITS'(MAX_COLUMNS);

  logic [kms_pkg::COUNT_BITS-1:0] wr_count;
  logic [kms_pkg::COUNT_BITS-1:0] rows_clamped;
  logic [kms_pkg::COUNT_BITS-1:0] cols_clamped;

  assign wr_count = wr_data[kms_pkg::COUNT_BITS-1:0];

  always_comb begin
    if (wr_count == '0) begin
      rows_clamped = kms_pkg::COUNT_BITS'(1);
      cols_clamped = kms_pkg::COUNT_BITS'(1);
    end else begin
      rows_clamped = (wr_count > ROWS_MAX) ? ROWS_MAX : wr_count;
      cols_clamped = (wr_count > COLS_MAX) ? COLS_MAX : wr_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_interval_ms <= kms_pkg::MIN_INTERVAL_RESET;
      cfg.rows <= ROWS_MAX;
      cfg.columns <= COLS_MAX;
    end else if (wr_en) begin
      case (wr_index)
        kms_pkg::REG_MIN_INTERVAL: cfg.min_interval_ms <= wr_data;
        kms_pkg::REG_ROWS_IN_USE: cfg.rows <= rows_clamped;
        kms_pkg::REG_COLUMNS_IN_USE: cfg.columns <= cols_clamped;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/kms_scan.sv -----
// kms_scan: scan state registers and the per-word row sampling logic.
// Depends on kms_pkg.
module kms_scan (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  logic tick,
  input  logic [kms_pkg::LINE_BITS-1:0] levels,
  input  kms_pkg::cfg_t cfg,
  output kms_pkg::result_t result
);

  logic [kms_pkg::MS_BITS-1:0] elapsed_ms, elapsed_ms_next, elapsed_inc;
  logic scanning, scanning_next;
  logic [kms_pkg::ROW_BITS-1:0] current_row, current_row_next;
  logic key_found, key_found_next;
  logic several_found, several_found_next;
  logic [kms_pkg::ROW_BITS-1:0] found_row, found_row_next;
  logic [kms_pkg::COL_BITS-1:0] found_column, found_column_next;
  logic [kms_pkg::CODE_BITS-1:0] last_code, last_code_next;

  logic [kms_pkg::LINE_BITS-1:0] col_mask, lows;
  logic [kms_pkg::COL_BITS-1:0] low_index;
  logic [kms_pkg::COUNT_BITS-1:0] row_inc;
  logic [kms_pkg::CODE_BITS-1:0] code;

  assign elapsed_inc = (tick && elapsed_ms != kms_pkg::ELAPSED_MAX) ?
                       elapsed_ms + kms_pkg::MS_BITS'(1) : elapsed_ms;
  assign col_mask = kms_pkg::LINE_BITS'(8'hFF >> (kms_pkg::COUNT_BITS'(8) - cfg.columns));
  assign lows = ~levels & col_mask;
  assign row_inc = {1'b0, current_row} + kms_pkg::COUNT_BITS'(1);

  always_comb begin
    low_index = '0;
    for (int i = kms_pkg::LINE_BITS - 1; i >= 0; i--) begin
      if (lows[i]) low_index = kms_pkg::COL_BITS'(i);
    end
  end

  always_comb begin
    elapsed_ms_next = elapsed_inc;
    scanning_next = scanning;
    current_row_next = current_row;
    key_found_next = key_found;
    several_found_next = several_found;
    found_row_next = found_row;
    found_column_next = found_column;
    last_code_next = last_code;
    code = kms_pkg::CODE_RELEASED;
    result = '0;
    result.row_drive = kms_pkg::ROWS_IDLE;
    result.event_kind = kms_pkg::EVENT_RELEASED;

    if (scanning) begin
      if (lows != '0) begin
        if (((lows & (lows - kms_pkg::LINE_BITS'(1))) != '0) || key_found) begin
          several_found_next = 1'b1;
        end else begin
          key_found_next = 1'b1;
          found_row_next = current_row;
          found_column_next = low_index;
        end
      end
      if (row_inc >= cfg.rows) begin
        scanning_next = 1'b0;
        current_row_next = '0;
        if (several_found_next) begin
          code = kms_pkg::CODE_SEVERAL;
        end else if (key_found_next) begin
          code = {kms_pkg::CODE_SINGLE_TAG, found_row_next, found_column_next};
        end
        if (code != last_code) begin
          last_code_next = code;
          result.event_valid = 1'b1;
          if (several_found_next) begin
            result.event_kind = kms_pkg::EVENT_SEVERAL;
          end else if (key_found_next) begin
            result.event_kind = kms_pkg::EVENT_SINGLE;
            result.key_row = found_row_next;
            result.key_column = found_column_next;
          end
        end
      end else begin
        current_row_next = row_inc[kms_pkg::ROW_BITS-1:0];
        result.row_drive = ~(kms_pkg::LINE_BITS'(1) << row_inc[kms_pkg::ROW_BITS-1:0]);
      end
    end else if (elapsed_inc >= cfg.min_interval_ms) begin
      scanning_next = 1'b1;
      current_row_next = '0;
      elapsed_ms_next = '0;
      key_found_next = 1'b0;
      several_found_next = 1'b0;
      found_row_next = '0;
      found_column_next = '0;
      result.row_drive = ~kms_pkg::LINE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ms <= kms_pkg::ELAPSED_MAX;
      scanning <= 1'b0;
      current_row <= '0;
      key_found <= 1'b0;
      several_found <= 1'b0;
      found_row <= '0;
      found_column <= '0;
      last_code <= kms_pkg::CODE_RELEASED;
    end else if (accept) begin
      elapsed_ms <= elapsed_ms_next;
      scanning <= scanning_next;
      current_row <= current_row_next;
      key_found <= key_found_next;
      several_found <= several_found_next;
      found_row <= found_row_next;
      found_column <= found_column_next;
      last_code <= last_code_next;
    end
  end

endmodule

// ----- rtl/keypad_matrix_scanner.sv -----
// keypad_matrix_scanner: top level, config registers, scan logic, result register.
// Depends on kms_pkg, kms_cfg, kms_scan.
//
// Usage:
//   Item channel (item_valid/item_stall) carries one word per cycle unless stalled:
//   ms_tick and the active-low column levels sampled under the previous row drive.
//   Result channel (result_valid/result_stall) returns one word per item:
//   row_drive for the next sample plus an optional changed-key event.
//   Config channel (cfg_valid/cfg_ready, always ready) writes min interval,
//   rows in use and columns in use by index; write only while idle.
// Timing:
//   Result word is registered and appears in the cycle after its item is accepted. One item
//   per cycle is sustained while result_stall is low; the single result register sets the rate.
// Stall:
//   While result_stall holds a waiting word, item_stall is raised and the
//   word is held. A new item is taken in the same cycle the old word leaves.
// Reset:
//   Synchronous; the elapsed count starts saturated so the first scan begins on the
//   first item, last reported state is all released, no result word is pending.
module keypad_matrix_scanner #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLUMNS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  logic ms_tick,
  input  logic [7:0] column_levels,
  output logic result_valid,
  input  logic result_stall,
  output logic [7:0] row_drive,
  output logic event_valid,
  output logic [1:0] event_kind,
  output logic [2:0] key_row,
  output logic [2:0] key_column,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  kms_pkg::cfg_t cfg;
  kms_pkg::result_t result;
  logic accept;

  assign cfg_ready = 1'b1;
  assign item_stall = result_valid && result_stall;
  assign accept = item_valid && !item_stall;

  kms_cfg #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .wr_en(cfg_valid && cfg_ready),
    .wr_index(cfg_index),
    .wr_data(cfg_data),
    .cfg(cfg)
  );

  kms_scan u_scan (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .tick(ms_tick),
    .levels(column_levels),
    .cfg(cfg),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_drive <= result.row_drive;
      event_valid <= result.event_valid;
      event_kind <= result.event_kind;
      key_row <= result.key_row;
      key_column <= result.key_column;
    end
  end

endmodule

// ----- rtl/kms_checker.sv -----
// kms_checker: port-level assertions for keypad_matrix_scanner, bound to the top.
// Depends on kms_pkg and keypad_matrix_scanner.
module kms_checker (
  input logic clk,
  input logic rst,
  input logic item_valid,
  input logic item_stall,
  input logic result_valid,
  input logic result_stall,
  input logic [7:0] row_drive,
  input logic event_valid,
  input logic [1:0] event_kind,
  input logic [2:0] key_row,
  input logic [2:0] key_column
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(row_drive) &&
      $stable(event_valid) && $stable(event_kind))
    else $error("stalled result word changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    item_stall == (result_valid && result_stall))
    else $error("item stall does not follow result stall");

  a_no_event_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !event_valid |->
      event_kind == kms_pkg::EVENT_RELEASED && key_row == 3'd0 && key_column == 3'd0)
    else $error("event fields set without event");

  a_one_row: assert property (@(posedge clk) disable iff (rst)
    result_valid && row_drive != kms_pkg::ROWS_IDLE |-> $onehot(~row_drive) && !event_valid)
    else $error("bad row drive");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && event_valid |->
      event_kind == kms_pkg::EVENT_RELEASED || event_kind == kms_pkg::EVENT_SINGLE ||
      (event_kind == kms_pkg::EVENT_SEVERAL && key_row == 3'd0 && key_column == 3'd0))
    else $error("bad event kind");

endmodule

bind keypad_matrix_scanner kms_checker u_kms_checker (.*);
